@@ rtl/msss_pkg.sv @@
// ----------------------------------------------------------------------------
// msss_pkg
// Shared types, register codes and digit/segment helpers for the
// multiplexed seven-segment scanner.
// ----------------------------------------------------------------------------
package msss_pkg;

    localparam int unsigned FRAME_BITS = 16;

    localparam logic ACTION_TICK = 1'b0;
    localparam logic ACTION_LOAD = 1'b1;

    localparam logic REG_REFRESH_PERIOD     = 1'b0;
    localparam logic REG_SEGMENT_ACTIVE_LOW = 1'b1;

    localparam logic [7:0]  REFRESH_PERIOD_RESET = 8'd2;
    localparam logic        ACTIVE_LOW_RESET     = 1'b1;
    localparam logic [13:0] DISPLAY_MODULUS      = 14'd10000;

    typedef struct packed {
        logic [FRAME_BITS-1:0] bits;
        logic [1:0]            digit;
    } frame_t;

    function automatic logic [13:0] mod_display(input logic [15:0] v);
        logic [15:0] r;
        r = v;
        if (r >= 16'd40000)
        begin
            r = r - 16'd40000;
        end
        if (r >= 16'd20000)
        begin
            r = r - 16'd20000;
        end
        if (r >= 16'd10000)
        begin
            r = r - 16'd10000;
        end
        return r[13:0];
    endfunction

    function automatic logic [15:0] quot_recip(input logic [1:0] pos);
        logic [15:0] r;
        case (pos)
            2'd0:    r = 16'd1;
            2'd1:    r = 16'd52429;
            2'd2:    r = 16'd5243;
            2'd3:    r = 16'd8389;
            default: r = 16'd1;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] quot_shift(input logic [1:0] pos);
        logic [4:0] s;
        case (pos)
            2'd0:    s = 5'd0;
            2'd1:    s = 5'd19;
            2'd2:    s = 5'd19;
            2'd3:    s = 5'd23;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    function automatic logic [7:0] seg_pattern(input logic [3:0] d);
        logic [7:0] p;
        case (d)
            4'd0:    p = 8'h3F;
            4'd1:    p = 8'h06;
            4'd2:    p = 8'h5B;
            4'd3:    p = 8'h4F;
            4'd4:    p = 8'h66;
            4'd5:    p = 8'h6D;
            4'd6:    p = 8'h7D;
            4'd7:    p = 8'h07;
            4'd8:    p = 8'h7F;
            4'd9:    p = 8'h6F;
            default: p = 8'h00;
        endcase
        return p;
    endfunction

    function automatic logic [7:0] digit_select(input logic [1:0] pos);
        return 8'h08 >> pos;
    endfunction

endpackage

@@ rtl/msss_if.sv @@
// ----------------------------------------------------------------------------
// msss_if
// Valid/ready channels: command items in, serial frame bits out.
// ----------------------------------------------------------------------------
interface msss_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [15:0] value;

    modport source (output valid, action, value, input ready);
    modport sink   (input valid, action, value, output ready);
endinterface

interface msss_out_if;
    logic       valid;
    logic       ready;
    logic       serial_bit;
    logic [3:0] bit_position;
    logic [1:0] active_digit;
    logic       latch_last;

    modport source (output valid, serial_bit, bit_position, active_digit, latch_last,
                    input ready);
    modport sink   (input valid, serial_bit, bit_position, active_digit, latch_last,
                    output ready);
endinterface

@@ rtl/msss_frame_tx.sv @@
// ----------------------------------------------------------------------------
// msss_frame_tx
// Frame serializer: holds one 16-bit frame and hands it out MSB first,
// one bit item per accepted handshake, flagging the last bit.
// ----------------------------------------------------------------------------
module msss_frame_tx (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  msss_pkg::frame_t  frame,
    output logic              can_load,
    msss_out_if.source        bits
);

    localparam int unsigned CNT_W    = $clog2(msss_pkg::FRAME_BITS);
    localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(msss_pkg::FRAME_BITS - 1);

    logic [msss_pkg::FRAME_BITS-1:0] shift_reg;
    logic [CNT_W-1:0]                cnt_reg;
    logic [1:0]                      digit_reg;
    logic                            valid_reg;
    logic                            last;
    logic                            take;

    assign last     = (cnt_reg == LAST_BIT);
    assign take     = valid_reg && bits.ready;
    assign can_load = !valid_reg || (take && last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            cnt_reg   <= '0;
        end
        else if (take)
        begin
            if (last)
            begin
                valid_reg <= 1'b0;
            end
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            shift_reg <= frame.bits;
            digit_reg <= frame.digit;
        end
        else if (take)
        begin
            shift_reg <= shift_reg << 1;
        end
    end

    assign bits.valid        = valid_reg;
    assign bits.serial_bit   = shift_reg[msss_pkg::FRAME_BITS-1];
    assign bits.bit_position = cnt_reg;
    assign bits.active_digit = digit_reg;
    assign bits.latch_last   = last;

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> can_load)
        else $error("frame loaded over a frame still in flight");

    a_bit_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (take && !last) |=> (valid_reg && cnt_reg == $past(cnt_reg) + CNT_W'(1)))
        else $error("bit position did not advance within a frame");

    a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (valid_reg && cnt_reg == '0))
        else $error("frame did not start at bit zero");

endmodule

@@ rtl/multiplexed_seven_segment_scanner_unit.sv @@
// ----------------------------------------------------------------------------
// multiplexed_seven_segment_scanner_unit
// Four-digit multiplexed seven-segment scanner with a 16-bit serial frame.
// A refresh tick passes s0, s1, s2 and s3 in turn, then loads the serializer.
// Throughput: one item per cycle while the pipe advances; one bit per cycle
// out of the serializer while ready is high; the pipe backs up while it is busy.
// Reset: number, digit and tick counter clear; period 2, active-low segments.
// ----------------------------------------------------------------------------
module multiplexed_seven_segment_scanner_unit (
    input  logic        clk,
    input  logic        rst_n,
    msss_in_if.sink     cmd,
    msss_out_if.source  bits,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0]  refresh_period_reg;
    logic        active_low_reg;

    logic        s0_valid_reg;
    logic        s0_action_reg;
    logic [15:0] s0_value_reg;

    logic [13:0] shown_number_reg;
    logic [13:0] shown_number_next;
    logic [1:0]  digit_index_reg;
    logic [1:0]  digit_index_next;
    logic [7:0]  tick_count_reg;
    logic [7:0]  tick_count_next;

    logic        s1_valid_reg;
    logic [13:0] s1_number_reg;
    logic [1:0]  s1_pos_reg;

    logic        s2_valid_reg;
    logic [13:0] s2_quot_reg;
    logic [1:0]  s2_pos_reg;

    logic        s3_valid_reg;
    logic [3:0]  s3_digit_reg;
    logic [1:0]  s3_pos_reg;

    logic        adv;
    logic        tx_can_load;
    logic        tx_load;
    logic        cfg_write;
    logic [8:0]  tick_inc;
    logic        refresh;
    logic        is_load;
    logic [29:0] scaled;
    logic [13:0] quot;
    logic [29:0] tens_prod;
    logic [13:0] tens;
    logic [3:0]  digit;
    logic [7:0]  seg;
    msss_pkg::frame_t frame;

    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_comb
    begin
        case (paddr[2])
            msss_pkg::REG_REFRESH_PERIOD:     prdata = {24'd0, refresh_period_reg};
            msss_pkg::REG_SEGMENT_ACTIVE_LOW: prdata = {31'd0, active_low_reg};
            default:                          prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            refresh_period_reg <= msss_pkg::REFRESH_PERIOD_RESET;
            active_low_reg     <= msss_pkg::ACTIVE_LOW_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                msss_pkg::REG_REFRESH_PERIOD:     refresh_period_reg <= pwdata[7:0];
                msss_pkg::REG_SEGMENT_ACTIVE_LOW: active_low_reg     <= pwdata[0];
                default:                          ;
            endcase
        end
    end

    // advance the whole pipe only when the last stage can drain
    assign adv       = !s3_valid_reg || tx_can_load;
    assign tx_load   = s3_valid_reg && tx_can_load;
    assign cmd.ready = adv;

    assign is_load  = s0_valid_reg && (s0_action_reg == msss_pkg::ACTION_LOAD);
    assign tick_inc = {1'b0, tick_count_reg} + 9'd1;
    assign refresh  = s0_valid_reg && (s0_action_reg == msss_pkg::ACTION_TICK)
                      && (tick_inc >= {1'b0, refresh_period_reg});

    always_comb
    begin
        shown_number_next = shown_number_reg;
        digit_index_next  = digit_index_reg;
        tick_count_next   = tick_count_reg;
        if (is_load)
        begin
            shown_number_next = msss_pkg::mod_display(s0_value_reg);
        end
        else if (refresh)
        begin
            tick_count_next  = 8'd0;
            digit_index_next = digit_index_reg + 2'd1;
        end
        else if (s0_valid_reg)
        begin
            tick_count_next = tick_inc[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg     <= 1'b0;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s3_valid_reg     <= 1'b0;
            shown_number_reg <= '0;
            digit_index_reg  <= '0;
            tick_count_reg   <= '0;
        end
        else if (adv)
        begin
            s0_valid_reg     <= cmd.valid;
            s1_valid_reg     <= refresh;
            s2_valid_reg     <= s1_valid_reg;
            s3_valid_reg     <= s2_valid_reg;
            shown_number_reg <= shown_number_next;
            digit_index_reg  <= digit_index_next;
            tick_count_reg   <= tick_count_next;
        end
    end

    // digit position via reciprocal multiply, then remainder by ten
    assign scaled    = 30'(s1_number_reg) * 30'(msss_pkg::quot_recip(s1_pos_reg));
    assign quot      = 14'(scaled >> msss_pkg::quot_shift(s1_pos_reg));
    assign tens_prod = 30'(s2_quot_reg) * 30'd52429;
    assign tens      = 14'(tens_prod[29:19]);
    assign digit     = 4'(s2_quot_reg - tens * 14'd10);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_action_reg <= cmd.action;
            s0_value_reg  <= cmd.value;
            s1_number_reg <= shown_number_reg;
            s1_pos_reg    <= digit_index_reg;
            s2_quot_reg   <= quot;
            s2_pos_reg    <= s1_pos_reg;
            s3_digit_reg  <= digit;
            s3_pos_reg    <= s2_pos_reg;
        end
    end

    assign seg = active_low_reg ? ~msss_pkg::seg_pattern(s3_digit_reg)
                                :  msss_pkg::seg_pattern(s3_digit_reg);
    assign frame.bits  = {seg, msss_pkg::digit_select(s3_pos_reg)};
    assign frame.digit = s3_pos_reg;

    msss_frame_tx u_frame_tx (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (tx_load),
        .frame    (frame),
        .can_load (tx_can_load),
        .bits     (bits)
    );

    a_number_range: assert property (@(posedge clk) disable iff (!rst_n)
        shown_number_reg < msss_pkg::DISPLAY_MODULUS)
        else $error("shown number out of range");

    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg |-> (s3_digit_reg <= 4'd9))
        else $error("extracted digit above nine");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_valid_reg && !adv) |=> (s3_valid_reg && $stable(s3_digit_reg)
                                    && $stable(s3_pos_reg)))
        else $error("pending digit lost during stall");

endmodule

@@ tb/multiplexed_seven_segment_scanner_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multiplexed_seven_segment_scanner_unit_tb
// Drives load and tick items into the scanner and predicts every serial frame
// bit. The scoreboard compares each accepted bit with the oldest predicted
// one. Register writes go through the APB port while the scanner is idle.
// The stimulus is a short directed pass over digits, value wrap and period
// corners, then a receiver hold-off, then random traffic under several
// settings with bursty input and a stalling output.
// ----------------------------------------------------------------------------
module multiplexed_seven_segment_scanner_unit_tb;

    localparam int DRAIN_SETTLE = 12;

    localparam int RX_ALWAYS = 0;
    localparam int RX_HALF   = 1;
    localparam int RX_SPARSE = 2;
    localparam int RX_CADENCE = 3;

    localparam logic [7:0] SEG_CODE [10] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
    };
    localparam int unsigned DIGIT_WEIGHT [4] = '{1, 10, 100, 1000};

    typedef struct packed {
        logic       serial_bit;
        logic [3:0] bit_position;
        logic [1:0] active_digit;
        logic       latch_last;
    } frame_bit_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    msss_in_if  cmd_ch ();
    msss_out_if bit_ch ();

    multiplexed_seven_segment_scanner_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_ch),
        .bits    (bit_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // scanner shadow state
    logic [7:0]  period_reg   = msss_pkg::REFRESH_PERIOD_RESET;
    logic        active_low   = msss_pkg::ACTIVE_LOW_RESET;
    logic [13:0] shown_num    = '0;
    logic [1:0]  digit_pos    = '0;
    logic [7:0]  tick_cnt     = '0;

    frame_bit_t  pending_bits [$];
    frame_bit_t  head_bit;
    frame_bit_t  got_bit;
    int          errors       = 0;
    int          burst_left   = 0;
    int          hold_request = 0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic void scan_step(input logic act, input logic [15:0] val);
        logic [8:0]  next_cnt;
        logic [7:0]  seg;
        logic [15:0] frame;
        int unsigned digit;
        frame_bit_t  fb;
        if (act == msss_pkg::ACTION_LOAD)
        begin
            shown_num = 14'(val % 16'd10000);
            return;
        end
        next_cnt = {1'b0, tick_cnt} + 9'd1;
        if (next_cnt < {1'b0, period_reg})
        begin
            tick_cnt = next_cnt[7:0];
            return;
        end
        tick_cnt = '0;
        digit = (int'(shown_num) / DIGIT_WEIGHT[digit_pos]) % 10;
        seg = SEG_CODE[digit];
        if (active_low)
        begin
            seg = ~seg;
        end
        frame = {seg, 8'h08 >> digit_pos};
        for (int k = 0; k < 16; k++)
        begin
            fb.serial_bit   = frame[15 - k];
            fb.bit_position = 4'(k);
            fb.active_digit = digit_pos;
            fb.latch_last   = (k == 15);
            pending_bits.push_back(fb);
        end
        digit_pos = digit_pos + 2'd1;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                scan_step(cmd_ch.action, cmd_ch.value);
            end
            if (bit_ch.valid && bit_ch.ready)
            begin
                got_bit = '{bit_ch.serial_bit, bit_ch.bit_position,
                            bit_ch.active_digit, bit_ch.latch_last};
                if (pending_bits.size() == 0)
                begin
                    $display("%0t: unexpected frame bit, expected none, actual %p",
                             $time, got_bit);
                    errors++;
                end
                else
                begin
                    head_bit = pending_bits.pop_front();
                    if (got_bit.serial_bit !== head_bit.serial_bit ||
                        got_bit.bit_position !== head_bit.bit_position ||
                        got_bit.active_digit !== head_bit.active_digit ||
                        got_bit.latch_last !== head_bit.latch_last)
                    begin
                        $display("%0t: frame bit mismatch, expected %p, actual %p",
                                 $time, head_bit, got_bit);
                        errors++;
                    end
                end
            end
        end
    end

    // output side: random stall patterns, plus long hold-offs on request
    initial
    begin
        int mode;
        int mode_left;
        int hold_left;
        int cadence;
        mode = RX_ALWAYS;
        mode_left = 0;
        hold_left = 0;
        cadence = 0;
        bit_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                bit_ch.ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = $urandom_range(RX_ALWAYS, RX_CADENCE);
                    mode_left = $urandom_range(16, 120);
                end
                mode_left--;
                cadence++;
                case (mode)
                    RX_ALWAYS:  bit_ch.ready <= 1'b1;
                    RX_HALF:    bit_ch.ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE:  bit_ch.ready <= ($urandom_range(0, 3) == 0);
                    default:    bit_ch.ready <= (cadence % 3 != 0);
                endcase
            end
        end
    end

    task automatic send_item(input logic act, input logic [15:0] val);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 4);
            if (gap > 0)
            begin
                cmd_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        cmd_ch.valid  <= 1'b1;
        cmd_ch.action <= act;
        cmd_ch.value  <= val;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        burst_left--;
        @(negedge clk);
    endtask

    task automatic send_ticks(input int count);
        for (int i = 0; i < count; i++)
        begin
            send_item(msss_pkg::ACTION_TICK, 16'($urandom_range(0, 65535)));
        end
    endtask

    task automatic drain;
        cmd_ch.valid <= 1'b0;
        burst_left = 0;
        while (pending_bits.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_SETTLE) @(negedge clk);
    endtask

    task automatic reg_write(input logic idx, input logic [31:0] data);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (idx == msss_pkg::REG_REFRESH_PERIOD)
        begin
            period_reg = data[7:0];
        end
        else
        begin
            active_low = data[0];
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [15:0] pick_value();
        logic [15:0] v;
        case ($urandom_range(0, 3))
            0:       v = 16'($urandom_range(0, 65535));
            1:       v = 16'($urandom_range(9990, 10009));
            2:       v = 16'($urandom_range(0, 99));
            default: v = 16'(10000 * $urandom_range(1, 6) + $urandom_range(0, 3) - 2);
        endcase
        return v;
    endfunction

    task automatic test_reset_state;
        // period 2 after reset: first tick holds, second refreshes
        send_ticks(2);
        drain();
    endtask

    task automatic test_load_and_digits;
        send_item(msss_pkg::ACTION_LOAD, 16'hFFFF);
        reg_write(msss_pkg::REG_REFRESH_PERIOD, 32'd1);
        reg_write(msss_pkg::REG_SEGMENT_ACTIVE_LOW, 32'd0);
        send_ticks(3);
        send_item(msss_pkg::ACTION_LOAD, 16'd9876);
        send_ticks(4);
        send_item(msss_pkg::ACTION_LOAD, 16'd11240);
        send_ticks(4);
        send_item(msss_pkg::ACTION_LOAD, 16'd0);
        send_ticks(1);
        send_item(msss_pkg::ACTION_LOAD, 16'd10000);
        drain();
    endtask

    task automatic test_period_corners;
        reg_write(msss_pkg::REG_SEGMENT_ACTIVE_LOW, 32'd1);
        reg_write(msss_pkg::REG_REFRESH_PERIOD, 32'd0);
        send_ticks(1);
        reg_write(msss_pkg::REG_REFRESH_PERIOD, 32'd255);
        send_ticks(3);
        // drop the period below the running count
        reg_write(msss_pkg::REG_REFRESH_PERIOD, 32'd2);
        send_ticks(1);
        drain();
    endtask

    task automatic test_backpressure;
        reg_write(msss_pkg::REG_REFRESH_PERIOD, 32'd1);
        hold_request = 400;
        send_item(msss_pkg::ACTION_LOAD, 16'd4729);
        send_ticks(24);
        drain();
    endtask

    task automatic test_random_traffic;
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       reg_write(msss_pkg::REG_REFRESH_PERIOD, 32'd1);
                1:       reg_write(msss_pkg::REG_REFRESH_PERIOD, 32'($urandom_range(2, 4)));
                2:       reg_write(msss_pkg::REG_REFRESH_PERIOD, 32'd1);
                default: reg_write(msss_pkg::REG_REFRESH_PERIOD, 32'($urandom_range(1, 6)));
            endcase
            reg_write(msss_pkg::REG_SEGMENT_ACTIVE_LOW, 32'(phase % 2));
            for (int i = 0; i < 13; i++)
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    send_item(msss_pkg::ACTION_LOAD, pick_value());
                end
                else
                begin
                    send_item(msss_pkg::ACTION_TICK, 16'($urandom_range(0, 65535)));
                end
            end
        end
        drain();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cmd_ch.valid  = 1'b0;
        cmd_ch.action = msss_pkg::ACTION_TICK;
        cmd_ch.value  = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_state();
        test_load_and_digits();
        test_period_corners();
        test_backpressure();
        test_random_traffic();

        drain();
        repeat (DRAIN_SETTLE) @(negedge clk);
        if (errors == 0 && pending_bits.size() == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("%0t: timeout, %0d frame bits outstanding", $time, pending_bits.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
